// ----- hdl/cttl_pkg.sv -----
// Shared types and codes for the cut-to-length feed controller.
// No dependencies; imported by every module of the block.
package cttl_pkg;

    localparam int ENC_W     = 32;
    localparam int LEN_W     = 31;
    localparam int PART_W    = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // item opcodes
    localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_TARGET = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic                    knife_pin;
        logic                    dir_one_pin;
        logic                    dir_two_pin;
        logic                    hand_one_pin;
        logic                    hand_two_pin;
        logic                    emergency_pin;
        logic                    mode_pin;
        logic signed [ENC_W-1:0] encoder_count;
    } cttl_in_t;

    typedef struct packed {
        logic              gear_forward;
        logic              gear_reverse;
        logic              gear_fast;
        logic              buzzer;
        logic              running;
        logic              waiting_for_cut;
        logic [PART_W-1:0] parts_done;
    } cttl_out_t;

    typedef struct packed {
        logic [LEN_W-1:0]  cut_length;
        logic [PART_W-1:0] part_target;
    } cttl_cfg_t;

    // switches after polarity fix, all active high
    typedef struct packed {
        logic auto_mode;
        logic emerg;
        logic hand_two;
        logic hand_one;
        logic dir_two;
        logic dir_one;
        logic knife;
    } cttl_sw_t;

    typedef struct packed {
        logic buzz;
        logic fast;
        logic rev;
        logic fwd;
    } cttl_pins_t;

endpackage

// ----- hdl/cttl_core.sv -----
// Controller state and the per-word update logic of the feed controller.
// Depends on cttl_pkg.
module cttl_core
    import cttl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  cttl_in_t  item,
    input  cttl_cfg_t cfg,
    output cttl_out_t result
);

    cttl_sw_t          sw_reg, sw_next;
    logic              run_reg, run_next;
    logic              cw_reg, cw_next;
    logic              spd_reg, spd_next;
    logic              snd_reg, snd_next;
    logic [PART_W-1:0] pc_reg, pc_next;
    logic [ENC_W-1:0]  org_reg, org_next;
    cttl_pins_t        pins_reg, pins_next;

    cttl_sw_t          sw_smp;
    logic [ENC_W-1:0]  enc;
    logic              knife_cut;
    logic [ENC_W-1:0]  org_auto;
    logic [ENC_W-1:0]  diff;
    logic              reached;

    function automatic cttl_pins_t gear_run(cttl_pins_t p, cttl_sw_t s, logic spd, logic snd);
        cttl_pins_t r;
        r = p;
        if (!s.auto_mode) begin
            if (s.hand_one) begin
                if (s.dir_one) r.fwd = 1'b1;
                else           r.rev = 1'b1;
            end
            if (s.hand_two) begin
                if (s.dir_two) r.fwd = 1'b1;
                else           r.rev = 1'b1;
            end
        end else begin
            r.fwd = 1'b1;
        end
        r.fast = spd;
        r.buzz = snd;
        return r;
    endfunction

    function automatic cttl_pins_t gear_stop(logic snd);
        cttl_pins_t r;
        r      = '0;
        r.buzz = snd;
        return r;
    endfunction

    assign enc = $unsigned(item.encoder_count);

    always_comb begin
        sw_smp.knife     = ~item.knife_pin;
        sw_smp.dir_one   = item.dir_one_pin;
        sw_smp.dir_two   = item.dir_two_pin;
        sw_smp.hand_one  = ~item.hand_one_pin;
        sw_smp.hand_two  = ~item.hand_two_pin;
        sw_smp.emerg     = item.emergency_pin;
        sw_smp.auto_mode = ~item.mode_pin;
    end

    // knife stroke while waiting re-bases the origin before the length test
    assign knife_cut = sw_smp.knife && cw_reg;
    assign org_auto  = knife_cut ? enc : org_reg;
    assign diff      = enc - org_auto;
    assign reached   = !diff[ENC_W-1] && (diff[LEN_W-1:0] >= cfg.cut_length);

    always_comb begin
        sw_next   = sw_reg;
        run_next  = run_reg;
        cw_next   = cw_reg;
        spd_next  = spd_reg;
        snd_next  = snd_reg;
        pc_next   = pc_reg;
        org_next  = org_reg;
        pins_next = pins_reg;
        unique case (item.op)
            OP_POLL: begin
                sw_next = sw_smp;
                if (sw_smp.emerg) begin
                    snd_next  = 1'b0;
                    pins_next = gear_stop(1'b0);
                end
                if (sw_smp.knife) pins_next = gear_stop(snd_next);
                if (run_reg && sw_smp.auto_mode) begin
                    if (knife_cut) begin
                        cw_next  = 1'b0;
                        pc_next  = pc_reg + 1'b1;
                        snd_next = 1'b0;
                        if (pc_next != cfg.part_target)
                            pins_next = gear_run(pins_next, sw_smp, spd_next, 1'b0);
                        org_next = enc;
                    end
                    if (!cw_next && reached) begin
                        snd_next  = 1'b1;
                        pins_next = gear_stop(1'b1);
                        cw_next   = 1'b1;
                    end
                    if (pc_next == cfg.part_target) begin
                        run_next = 1'b0;
                        spd_next = 1'b1;
                    end
                end else if (!sw_smp.auto_mode) begin
                    if (sw_smp.knife) org_next = enc;
                    if (sw_smp.hand_one && sw_smp.hand_two)
                        pins_next = gear_stop(snd_next);
                    else if (sw_smp.hand_one || sw_smp.hand_two)
                        pins_next = gear_run(pins_next, sw_smp, spd_next, snd_next);
                    else
                        pins_next = gear_stop(snd_next);
                end
            end
            OP_START: begin
                // start uses the switches latched by the last poll
                run_next  = 1'b1;
                org_next  = enc;
                pins_next = gear_run(pins_reg, sw_reg, spd_reg, snd_reg);
            end
            OP_CLEAR: begin
                cw_next  = 1'b0;
                pc_next  = '0;
                org_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= '0;
            run_reg  <= 1'b0;
            cw_reg   <= 1'b0;
            spd_reg  <= 1'b0;
            snd_reg  <= 1'b0;
            pc_reg   <= '0;
            org_reg  <= '0;
            pins_reg <= '0;
        end else if (advance) begin
            sw_reg   <= sw_next;
            run_reg  <= run_next;
            cw_reg   <= cw_next;
            spd_reg  <= spd_next;
            snd_reg  <= snd_next;
            pc_reg   <= pc_next;
            org_reg  <= org_next;
            pins_reg <= pins_next;
        end
    end

    always_comb begin
        result.gear_forward    = pins_next.fwd;
        result.gear_reverse    = pins_next.rev;
        result.gear_fast       = pins_next.fast;
        result.buzzer          = pins_next.buzz;
        result.running         = run_next;
        result.waiting_for_cut = cw_next;
        result.parts_done      = pc_next;
    end

    // speed select, once set, is only cleared by reset
    a_spd_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        spd_reg |=> spd_reg)
        else $error("speed flag dropped");

    // state only moves when a word is processed
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(pc_reg) && $stable(cw_reg) && $stable(pins_reg))
        else $error("state changed without a word");

    // part count only steps by one, or goes back to zero on clear
    a_pc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (pc_reg == $past(pc_reg)) || (pc_reg == $past(pc_reg) + 1'b1)
                    || (pc_reg == '0))
        else $error("part count jumped");

endmodule

// ----- hdl/cut_to_length_feed_controller_unit.sv -----
// Result path: input register, then result register, from input acceptance to result valid.
// Throughput: one word per cycle, sustained, when the result side keeps m_ready high.
// A word in the input register moves on whenever the result register is empty or being read.
// Reset: aresetn synchronous, active low; clears both stages, all control flags,
// the part counter, the cut origin, the drive pins and both config registers.
module cut_to_length_feed_controller_unit
    import cttl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // poll / start / clear words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cttl_in_t             s_data,

    // one result word per input word
    output logic                 m_valid,
    input  logic                 m_ready,
    output cttl_out_t            m_data,

    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // input stage
    logic              in_valid_reg, in_valid_next;
    cttl_in_t          in_data_reg;

    // result stage
    logic              out_valid_reg, out_valid_next;
    cttl_out_t         out_data_reg;

    // live configuration; read by the core each word
    logic [LEN_W-1:0]  cut_length_reg;
    logic [PART_W-1:0] part_target_reg;

    logic              out_free;
    logic              advance;
    logic              s_take;
    cttl_cfg_t         cfg;
    cttl_out_t         result;

    // the result slot frees up in the same cycle it is read
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    assign cfg_ready = 1'b1;

    assign cfg.cut_length  = cut_length_reg;
    assign cfg.part_target = part_target_reg;

    cttl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_take)  in_data_reg  <= s_data;
        if (advance) out_data_reg <= result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cut_length_reg  <= '0;
            part_target_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CUT_LENGTH:  cut_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_PART_TARGET: part_target_reg <= cfg_data[PART_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a word held in the input stage is never dropped while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("input word lost under stall");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("result word overwritten");

    // each processed word produces a visible result next cycle
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result missing after processing");

endmodule
